/* hdl/spiseq_pkg.sv */
// Shared types, opcodes and codes for the SPI EEPROM transfer sequencer.
package spiseq_pkg;

	// Default page size of the EEPROM in bytes
	localparam int unsigned PAGE_SIZE_DEF = 32;

	// Field widths
	localparam int unsigned FUNC_W  = 2;
	localparam int unsigned ADDR_W  = 16;
	localparam int unsigned COUNT_W = 17;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CS_W    = 2;
	localparam int unsigned OFS_W   = 9;

	// Function codes of an input word
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_XFER  = 2'd2;

	// Chip-select actions
	localparam logic [CS_W-1:0] CS_NONE     = 2'd0;
	localparam logic [CS_W-1:0] CS_SELECT   = 2'd1;
	localparam logic [CS_W-1:0] CS_RELEASE  = 2'd2;
	localparam logic [CS_W-1:0] CS_RESELECT = 2'd3;

	// EEPROM opcodes and fixed bytes
	localparam logic [BYTE_W-1:0] OP_RDSR    = 8'h05;
	localparam logic [BYTE_W-1:0] OP_WREN    = 8'h06;
	localparam logic [BYTE_W-1:0] OP_WRITE   = 8'h02;
	localparam logic [BYTE_W-1:0] OP_READ    = 8'h03;
	localparam logic [BYTE_W-1:0] DUMMY_BYTE = 8'h00;

	// Sequencer phases, one-hot
	typedef enum logic [7:0] {
		PH_IDLE      = 8'b0000_0001,
		PH_STAT_DUMY = 8'b0000_0010,
		PH_STAT_CHK  = 8'b0000_0100,
		PH_WR_OPC    = 8'b0000_1000,
		PH_ADDR_HI   = 8'b0001_0000,
		PH_ADDR_LO   = 8'b0010_0000,
		PH_RD_DUMY   = 8'b0100_0000,
		PH_DATA      = 8'b1000_0000
	} phase_t;

	// Transfer state
	typedef struct packed {
		phase_t               phase;
		logic                 is_write;
		logic [ADDR_W-1:0]    cur_address;
		logic [COUNT_W-1:0]   bytes_left;
		logic [OFS_W-1:0]     page_offset;
		logic [ADDR_W-1:0]    page_base;
	} state_t;

	// One result word
	typedef struct packed {
		logic              tx_valid;
		logic [BYTE_W-1:0] tx_byte;
		logic [CS_W-1:0]   cs_action;
		logic              read_valid;
		logic [BYTE_W-1:0] read_data;
		logic              write_taken;
		logic              done_res;
		logic              busy_res;
	} result_t;

	// Page split of a start address, from the divider
	typedef struct packed {
		logic              valid;
		logic [OFS_W-1:0]  page_offset;
		logic [ADDR_W-1:0] page_base;
	} page_split_t;

endpackage

/* hdl/spiseq_pgdiv.sv */
// Splits a start address into page base and page offset; the address and the estimated quotient are registered.
module spiseq_pgdiv #(
	parameter int unsigned PAGE_SIZE = spiseq_pkg::PAGE_SIZE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [spiseq_pkg::ADDR_W-1:0]      addr,
	output spiseq_pkg::page_split_t            split
);

	// Reciprocal of the page size, 32 fractional bits
	localparam longint unsigned RECIP_L = (64'd1 << 32) / PAGE_SIZE;
	localparam logic [31:0]     RECIP   = 32'(RECIP_L);
	localparam logic [spiseq_pkg::OFS_W-1:0] PS = spiseq_pkg::OFS_W'(PAGE_SIZE);

	logic [spiseq_pkg::ADDR_W-1:0] addr_q;
	logic                          valid_s1;
	logic                          valid_s2;
	logic [spiseq_pkg::ADDR_W-1:0] quot_s2;
	logic [47:0]                   prod_a;
	logic [24:0]                   prod_b;
	logic [16:0]                   rem_raw;
	logic [16:0]                   rem_fix;

	// Control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	// Estimated quotient, low by at most one
	assign prod_a = {32'd0, addr_q} * {16'd0, RECIP};

	always_ff @(posedge clk) begin
		if (start) begin
			addr_q <= addr;
		end
		if (valid_s1) begin
			quot_s2 <= prod_a[47:32];
		end
	end

	// Remainder with a single correction step
	assign prod_b  = {9'd0, quot_s2} * {16'd0, PS};
	assign rem_raw = {1'b0, addr_q} - prod_b[16:0];
	assign rem_fix = (rem_raw >= 17'(PAGE_SIZE)) ? rem_raw - 17'(PAGE_SIZE) : rem_raw;

	assign split.valid       = valid_s2;
	assign split.page_offset = rem_fix[spiseq_pkg::OFS_W-1:0];
	assign split.page_base   = addr_q - {7'd0, rem_fix[spiseq_pkg::OFS_W-1:0]};

endmodule

/* hdl/spiseq_step.sv */
// Next-state and result decode for one input word of the sequencer.
module spiseq_step #(
	parameter int unsigned PAGE_SIZE = spiseq_pkg::PAGE_SIZE_DEF
) (
	input  spiseq_pkg::state_t                 cur,
	input  logic [spiseq_pkg::FUNC_W-1:0]      func,
	input  logic [spiseq_pkg::ADDR_W-1:0]      start_address,
	input  logic [spiseq_pkg::COUNT_W-1:0]     byte_count,
	input  logic [spiseq_pkg::BYTE_W-1:0]      rx_byte,
	input  logic [spiseq_pkg::BYTE_W-1:0]      write_byte,
	output spiseq_pkg::state_t                 nxt,
	output spiseq_pkg::result_t                res,
	output logic                               start_go
);

	localparam logic [spiseq_pkg::OFS_W-1:0]  PS_OFS  = spiseq_pkg::OFS_W'(PAGE_SIZE);
	localparam logic [spiseq_pkg::ADDR_W-1:0] PS_ADDR = spiseq_pkg::ADDR_W'(PAGE_SIZE);

	logic [spiseq_pkg::COUNT_W-1:0] left_dec;
	logic [spiseq_pkg::ADDR_W-1:0]  next_base;

	assign left_dec  = cur.bytes_left - 17'd1;
	assign next_base = cur.page_base + PS_ADDR;

	always_comb begin
		nxt      = cur;
		res      = '0;
		start_go = 1'b0;
		unique case (func) inside
			// Start of a read or write
			spiseq_pkg::FUNC_READ, spiseq_pkg::FUNC_WRITE: begin
				if (cur.phase == spiseq_pkg::PH_IDLE &&
				    !(func == spiseq_pkg::FUNC_READ && byte_count == '0)) begin
					nxt.is_write    = (func == spiseq_pkg::FUNC_WRITE);
					nxt.cur_address = start_address;
					nxt.bytes_left  = byte_count;
					nxt.page_offset = '0;
					nxt.phase       = spiseq_pkg::PH_STAT_DUMY;
					res.tx_valid    = 1'b1;
					res.tx_byte     = spiseq_pkg::OP_RDSR;
					res.cs_action   = spiseq_pkg::CS_SELECT;
					start_go        = 1'b1;
				end
			end
			// One byte exchange finished on the link
			spiseq_pkg::FUNC_XFER: begin
				unique case (cur.phase)
					spiseq_pkg::PH_IDLE: begin
					end
					spiseq_pkg::PH_STAT_DUMY: begin
						res.tx_valid = 1'b1;
						res.tx_byte  = spiseq_pkg::DUMMY_BYTE;
						nxt.phase    = spiseq_pkg::PH_STAT_CHK;
					end
					spiseq_pkg::PH_STAT_CHK: begin
						res.tx_valid = 1'b1;
						if (!rx_byte[0]) begin
							res.cs_action = spiseq_pkg::CS_RESELECT;
							if (cur.is_write) begin
								res.tx_byte = spiseq_pkg::OP_WREN;
								nxt.phase   = spiseq_pkg::PH_WR_OPC;
							end else begin
								res.tx_byte = spiseq_pkg::OP_READ;
								nxt.phase   = spiseq_pkg::PH_ADDR_HI;
							end
						end else begin
							res.tx_byte = spiseq_pkg::DUMMY_BYTE;
						end
					end
					spiseq_pkg::PH_WR_OPC: begin
						res.cs_action = spiseq_pkg::CS_RESELECT;
						res.tx_valid  = 1'b1;
						res.tx_byte   = spiseq_pkg::OP_WRITE;
						nxt.phase     = spiseq_pkg::PH_ADDR_HI;
					end
					spiseq_pkg::PH_ADDR_HI: begin
						res.tx_valid = 1'b1;
						res.tx_byte  = cur.cur_address[15:8];
						nxt.phase    = spiseq_pkg::PH_ADDR_LO;
					end
					spiseq_pkg::PH_ADDR_LO: begin
						res.tx_valid = 1'b1;
						res.tx_byte  = cur.cur_address[7:0];
						nxt.phase    = cur.is_write ? spiseq_pkg::PH_DATA
						                            : spiseq_pkg::PH_RD_DUMY;
					end
					spiseq_pkg::PH_RD_DUMY: begin
						res.tx_valid = 1'b1;
						res.tx_byte  = spiseq_pkg::DUMMY_BYTE;
						nxt.phase    = spiseq_pkg::PH_DATA;
					end
					spiseq_pkg::PH_DATA: begin
						if (!cur.is_write) begin
							// read data returns; last byte releases the chip
							res.read_valid = 1'b1;
							res.read_data  = rx_byte;
							nxt.bytes_left = left_dec;
							if (left_dec != '0) begin
								res.tx_valid = 1'b1;
								res.tx_byte  = spiseq_pkg::DUMMY_BYTE;
							end else begin
								res.cs_action = spiseq_pkg::CS_RELEASE;
								res.done_res  = 1'b1;
								nxt.phase     = spiseq_pkg::PH_IDLE;
							end
						end else if (cur.bytes_left != '0) begin
							if (cur.page_offset >= PS_OFS) begin
								// page full: poll, enable and address the next page
								nxt.page_offset = '0;
								nxt.page_base   = next_base;
								nxt.cur_address = next_base;
								nxt.phase       = spiseq_pkg::PH_STAT_DUMY;
								res.cs_action   = spiseq_pkg::CS_RESELECT;
								res.tx_valid    = 1'b1;
								res.tx_byte     = spiseq_pkg::OP_RDSR;
							end else begin
								nxt.page_offset = cur.page_offset + 9'd1;
								nxt.bytes_left  = left_dec;
								res.tx_valid    = 1'b1;
								res.tx_byte     = write_byte;
								res.write_taken = 1'b1;
							end
						end else begin
							res.cs_action = spiseq_pkg::CS_RELEASE;
							res.done_res  = 1'b1;
							nxt.phase     = spiseq_pkg::PH_IDLE;
						end
					end
					default: begin
						nxt.phase = spiseq_pkg::PH_IDLE;
					end
				endcase
			end
			default: begin
			end
		endcase
		res.busy_res = (nxt.phase != spiseq_pkg::PH_IDLE);
	end

endmodule

/* hdl/spi_eeprom_transfer_sequencer.sv */
// Top level of the SPI EEPROM transfer sequencer.
//
// Input channel (in_valid/in_ready): each word is either a start (func read
// or write, with start_address and byte_count) or the report of one finished
// SPI byte exchange (func exchange, with rx_byte and the next write_byte).
// Output channel (out_valid/out_ready): one result word per input word, with
// the byte to shift out, the chip-select action, read data, whether
// write_byte was used, completion and busy.
// Each word passes an input register, then the decode into the result
// register. Throughput is one word per clock while the receiver takes
// results, set by the combinational decode of the phase state machine.
// A start word also launches a page divider that fills in the page offset
// and page base while the status poll runs, well before the first data byte.
// Reset (arst_n low) returns the sequencer to idle and empties both
// registers. When the receiver stalls, the result register holds its word,
// the input register takes one more word, then in_ready falls.
module spi_eeprom_transfer_sequencer #(
	parameter int unsigned PAGE_SIZE = spiseq_pkg::PAGE_SIZE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [spiseq_pkg::FUNC_W-1:0]      func,
	input  logic [spiseq_pkg::ADDR_W-1:0]      start_address,
	input  logic [spiseq_pkg::COUNT_W-1:0]     byte_count,
	input  logic [spiseq_pkg::BYTE_W-1:0]      rx_byte,
	input  logic [spiseq_pkg::BYTE_W-1:0]      write_byte,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               tx_valid,
	output logic [spiseq_pkg::BYTE_W-1:0]      tx_byte,
	output logic [spiseq_pkg::CS_W-1:0]        cs_action,
	output logic                               read_valid,
	output logic [spiseq_pkg::BYTE_W-1:0]      read_data,
	output logic                               write_taken,
	output logic                               done_res,
	output logic                               busy_res
);

	logic                            valid_s1;
	logic [spiseq_pkg::FUNC_W-1:0]   func_s1;
	logic [spiseq_pkg::ADDR_W-1:0]   addr_s1;
	logic [spiseq_pkg::COUNT_W-1:0]  count_s1;
	logic [spiseq_pkg::BYTE_W-1:0]   rx_s1;
	logic [spiseq_pkg::BYTE_W-1:0]   wb_s1;
	logic                            out_valid_q;
	spiseq_pkg::result_t             res_q;
	spiseq_pkg::state_t              st_q;
	spiseq_pkg::state_t              st_nxt;
	spiseq_pkg::state_t              st_d;
	spiseq_pkg::result_t             res_nxt;
	spiseq_pkg::page_split_t         split;
	logic                            start_go;
	logic                            advance;

	// Handshake
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1  <= func;
			addr_s1  <= start_address;
			count_s1 <= byte_count;
			rx_s1    <= rx_byte;
			wb_s1    <= write_byte;
		end
	end

	// Decode of the held word
	spiseq_step #(
		.PAGE_SIZE(PAGE_SIZE)
	) u_step (
		.cur          (st_q),
		.func         (func_s1),
		.start_address(addr_s1),
		.byte_count   (count_s1),
		.rx_byte      (rx_s1),
		.write_byte   (wb_s1),
		.nxt          (st_nxt),
		.res          (res_nxt),
		.start_go     (start_go)
	);

	// Page split of the start address
	spiseq_pgdiv #(
		.PAGE_SIZE(PAGE_SIZE)
	) u_pgdiv (
		.clk   (clk),
		.arst_n(arst_n),
		.start (advance && start_go),
		.addr  (addr_s1),
		.split (split)
	);

	// Transfer state; the divider result lands during the status poll
	always_comb begin
		st_d = st_q;
		if (advance) begin
			st_d = st_nxt;
		end
		if (split.valid) begin
			st_d.page_offset = split.page_offset;
			st_d.page_base   = split.page_base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: spiseq_pkg::PH_IDLE, default: '0};
		end else begin
			st_q <= st_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid   = out_valid_q;
	assign tx_valid    = res_q.tx_valid;
	assign tx_byte     = res_q.tx_byte;
	assign cs_action   = res_q.cs_action;
	assign read_valid  = res_q.read_valid;
	assign read_data   = res_q.read_data;
	assign write_taken = res_q.write_taken;
	assign done_res    = res_q.done_res;
	assign busy_res    = res_q.busy_res;

endmodule

/* hdl/spiseq_checker.sv */
// Port-level checks for the SPI EEPROM transfer sequencer, bound to the top.
module spiseq_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic                               tx_valid,
	input logic [spiseq_pkg::BYTE_W-1:0]      tx_byte,
	input logic [spiseq_pkg::CS_W-1:0]        cs_action,
	input logic                               read_valid,
	input logic                               write_taken,
	input logic                               done_res,
	input logic                               busy_res
);

	// A stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(cs_action))
		else $error("result word changed while stalled");

	// Completion ends the transfer and releases the chip
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res && cs_action == spiseq_pkg::CS_RELEASE)
		else $error("done without release or still busy");

	// A write data byte is sent plainly, with no chip-select change
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_taken |-> tx_valid && busy_res && !read_valid &&
			cs_action == spiseq_pkg::CS_NONE)
		else $error("write byte taken without being sent");

	// A read byte either asks for the next byte or ends the transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_valid |-> tx_valid != done_res)
		else $error("read byte with inconsistent follow-up");

	// Nothing to shift out means a zero byte
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tx_valid |-> tx_byte == spiseq_pkg::DUMMY_BYTE)
		else $error("tx byte not zero while idle");

endmodule

bind spi_eeprom_transfer_sequencer spiseq_checker u_spiseq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.tx_valid   (tx_valid),
	.tx_byte    (tx_byte),
	.cs_action  (cs_action),
	.read_valid (read_valid),
	.write_taken(write_taken),
	.done_res   (done_res),
	.busy_res   (busy_res)
);
